FILE: rtl/abd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abd_pkg : shared types and constants of the anchor box decoder
// Fixed-point formats, sigmoid breakpoints and the anchor grid layout.
// ---------------------------------------------------------------------------
package abd_pkg;

   localparam int IndexWidth = 10;
   localparam int ScoreWidth = 16;
   localparam int RegWidth   = 18;
   localparam int CoordWidth = 19;
   localparam int MagWidth   = 15;

   typedef logic [IndexWidth-1:0]        index_type;
   typedef logic signed [ScoreWidth-1:0] logit_type;
   typedef logic [ScoreWidth-1:0]        conf_type;
   typedef logic signed [RegWidth-1:0]   regr_type;
   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [MagWidth-1:0]          mag_type;

   // Logit clip at +-100.0 in Q8.8
   localparam logit_type ClipPos = 16'sd25600;
   localparam logit_type ClipNeg = -16'sd25600;

   // Sigmoid segment breakpoints on |x| in Q8.8
   localparam mag_type SigKnee0 = 15'd256;
   localparam mag_type SigKnee1 = 15'd608;
   localparam mag_type SigKnee2 = 15'd1280;

   localparam logic [16:0] SigBase0 = 17'd32768;
   localparam logic [16:0] SigBase1 = 17'd40960;
   localparam logic [16:0] SigBase2 = 17'd55296;
   localparam logic [16:0] SigOne   = 17'd65536;
   localparam conf_type    ConfMax  = 16'hFFFF;

   localparam conf_type ThresholdReset = 16'd32768;

   // Coarse grid: cell = (index - 512) / 6 through a reciprocal of 171 / 1024,
   // exact for every offset below 512
   localparam logic [7:0] DivSixMul   = 8'd171;
   localparam int         DivSixShift = 10;
   localparam logic [6:0] CoarseLast  = 7'd63;

endpackage
`default_nettype wire

FILE: rtl/abd_anchor.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abd_anchor : anchor centre lookup
// Maps an anchor index to its cell centre in Q0.15 on the fine or coarse grid.
// ---------------------------------------------------------------------------
module abd_anchor (
   input  wire abd_pkg::index_type anchor_index,
   output abd_pkg::mag_type        centre_x,
   output abd_pkg::mag_type        centre_y
);

   logic [16:0] prod;
   logic [6:0]  quot;
   logic [5:0]  coarse_pos;

   always_comb begin
      prod = 17'(anchor_index[8:0]) * 17'(abd_pkg::DivSixMul);
      quot = prod[16:abd_pkg::DivSixShift];
      // clamp past-the-end indices onto the last coarse cell
      coarse_pos = (quot > abd_pkg::CoarseLast) ? abd_pkg::CoarseLast[5:0] : quot[5:0];
      if (!anchor_index[9]) begin
         centre_x = {anchor_index[4:1], 1'b1, 10'b0};
         centre_y = {anchor_index[8:5], 1'b1, 10'b0};
      end else begin
         centre_x = {coarse_pos[2:0], 1'b1, 11'b0};
         centre_y = {coarse_pos[5:3], 1'b1, 11'b0};
      end
   end

endmodule
`default_nettype wire

FILE: rtl/abd_sigmoid.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abd_sigmoid : piecewise-linear sigmoid
// Four segments on |x|, mirrored for negative logits, saturated to Q0.16.
// ---------------------------------------------------------------------------
module abd_sigmoid (
   input  wire abd_pkg::mag_type  mag,
   input  wire                    negative,
   output abd_pkg::conf_type      confidence
);

   logic [16:0] pos;
   logic [16:0] val;
   logic [16:0] mag_ext;

   always_comb begin
      mag_ext = {2'b0, mag};
      priority if (mag >= abd_pkg::SigKnee2) begin
         pos = abd_pkg::SigOne;
      end else if (mag >= abd_pkg::SigKnee1) begin
         pos = (mag_ext << 3) + abd_pkg::SigBase2;
      end else if (mag >= abd_pkg::SigKnee0) begin
         pos = (mag_ext << 5) + abd_pkg::SigBase1;
      end else begin
         pos = (mag_ext << 6) + abd_pkg::SigBase0;
      end
      val = negative ? (abd_pkg::SigOne - pos) : pos;
      confidence = val[16] ? abd_pkg::ConfMax : val[15:0];
   end

endmodule
`default_nettype wire

FILE: rtl/abd_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abd_edge : box edge pair along one axis
// min = round((2c - s) / 2), max = round((2c + s) / 2), ties rounded up.
// ---------------------------------------------------------------------------
module abd_edge (
   input  wire abd_pkg::coord_type centre,
   input  wire abd_pkg::regr_type  size,
   output abd_pkg::coord_type      low_edge,
   output abd_pkg::coord_type      high_edge
);

   logic signed [20:0] twice;
   logic signed [20:0] size_ext;
   logic signed [20:0] lo_sum;
   logic signed [20:0] hi_sum;

   always_comb begin
      twice    = {{1{centre[18]}}, centre, 1'b0};
      size_ext = {{3{size[17]}}, size};
      lo_sum   = twice - size_ext + 21'sd1;
      hi_sum   = twice + size_ext + 21'sd1;
      low_edge  = lo_sum[19:1];
      high_edge = hi_sum[19:1];
   end

endmodule
`default_nettype wire

FILE: rtl/anchor_box_decode_threshold_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// anchor_box_decode_threshold_core : anchor decode with score threshold
// Sigmoid on the logit, threshold test, box and keypoint decode per row.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_tvalid/tready   | req_tdata  : detector row
//  rsp_    | out       | rsp_tvalid/tready   | rsp_tdata  : decoded detection
//  csr_    | in        | csr_valid/ready     | csr_data   : score_threshold
//
//  One row a cycle sustained while rsp_ is not stalled; four register stages,
//  and a detection shows on rsp_ from the last of them. Rows under threshold
//  are dropped in stage three and leave a bubble. Reset clears the stage
//  valid bits and sets the threshold to 0.5. A stall on rsp_ holds each full
//  stage; empty stages keep filling, and req_tready falls only once all four
//  stages are full.
// ---------------------------------------------------------------------------
module anchor_box_decode_threshold_core (
   input  wire          clock,
   input  wire          reset,
   // anchor_index[9:0], raw_score[25:10], box_center_x, box_center_y,
   // box_width, box_height, first_point_x, first_point_y, second_point_x,
   // second_point_y (18 bits each from bit 26 up), zero pad [175:170]
   input  wire  [175:0] req_tdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   // hit_index[9:0], confidence[25:10], left_edge, top_edge, right_edge,
   // bottom_edge, point_a_x, point_a_y, point_b_x, point_b_y (19 bits each
   // from bit 26 up), zero pad [183:178]
   output logic [183:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [15:0]  csr_data,
   input  wire          csr_valid,
   output logic         csr_ready
);

   // ---------------- configuration ----------------
   abd_pkg::conf_type threshold_ff, threshold_in;

   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= abd_pkg::ThresholdReset;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // ---------------- stall control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;
   logic hit;

   // a stage moves on when empty or when the next one moves
   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   assign v1_in = adv1 ? req_tvalid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? (v3_ff && hit) : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------- stage 1 : capture the row ----------------
   logic [169:0] row_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         row_ff <= req_tdata[169:0];
      end
   end

   abd_pkg::index_type s1_idx;
   abd_pkg::logit_type s1_logit, s1_clip;
   abd_pkg::regr_type  s1_reg [8];
   abd_pkg::mag_type   s1_mag;
   abd_pkg::mag_type   s1_ax, s1_ay;

   assign s1_idx   = row_ff[9:0];
   assign s1_logit = row_ff[25:10];

   for (genvar g = 0; g < 8; g++) begin : g_unpack
      assign s1_reg[g] = row_ff[26 + 18*g +: 18];
   end

   // clip to +-100 and take the magnitude
   always_comb begin
      priority if (s1_logit > abd_pkg::ClipPos) begin
         s1_clip = abd_pkg::ClipPos;
      end else if (s1_logit < abd_pkg::ClipNeg) begin
         s1_clip = abd_pkg::ClipNeg;
      end else begin
         s1_clip = s1_logit;
      end
      s1_mag = s1_clip[15] ? 15'(-s1_clip) : s1_clip[14:0];
   end

   abd_anchor u_anchor (
      .anchor_index (s1_idx),
      .centre_x     (s1_ax),
      .centre_y     (s1_ay)
   );

   // ---------------- stage 2 : magnitude and anchor centre ----------------
   abd_pkg::index_type s2_idx_ff;
   abd_pkg::mag_type   s2_mag_ff, s2_ax_ff, s2_ay_ff;
   logic               s2_neg_ff;
   abd_pkg::regr_type  s2_reg_ff [8];

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_idx_ff <= s1_idx;
         s2_mag_ff <= s1_mag;
         s2_neg_ff <= s1_clip[15];
         s2_ax_ff  <= s1_ax;
         s2_ay_ff  <= s1_ay;
         s2_reg_ff <= s1_reg;
      end
   end

   abd_pkg::conf_type  s2_conf;
   abd_pkg::coord_type s2_ax_s, s2_ay_s;
   abd_pkg::coord_type s2_sum [8];

   abd_sigmoid u_sigmoid (
      .mag        (s2_mag_ff),
      .negative   (s2_neg_ff),
      .confidence (s2_conf)
   );

   assign s2_ax_s = {4'b0, s2_ax_ff};
   assign s2_ay_s = {4'b0, s2_ay_ff};

   // offset centre and keypoints; size terms pass through sign extended
   for (genvar g = 0; g < 8; g++) begin : g_offset
      if (g == 2 || g == 3) begin : g_size
         assign s2_sum[g] = {s2_reg_ff[g][17], s2_reg_ff[g]};
      end else begin : g_add
         assign s2_sum[g] = {s2_reg_ff[g][17], s2_reg_ff[g]}
                          + ((g % 2 == 0) ? s2_ax_s : s2_ay_s);
      end
   end

   // ---------------- stage 3 : threshold and edges ----------------
   abd_pkg::index_type s3_idx_ff;
   abd_pkg::conf_type  s3_conf_ff;
   abd_pkg::coord_type s3_sum_ff [8];

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_idx_ff  <= s2_idx_ff;
         s3_conf_ff <= s2_conf;
         s3_sum_ff  <= s2_sum;
      end
   end

   abd_pkg::coord_type s3_left, s3_right, s3_top, s3_bottom;

   assign hit = s3_conf_ff >= threshold_ff;

   abd_edge u_edge_x (
      .centre    (s3_sum_ff[0]),
      .size      (s3_sum_ff[2][17:0]),
      .low_edge  (s3_left),
      .high_edge (s3_right)
   );

   abd_edge u_edge_y (
      .centre    (s3_sum_ff[1]),
      .size      (s3_sum_ff[3][17:0]),
      .low_edge  (s3_top),
      .high_edge (s3_bottom)
   );

   // ---------------- stage 4 : output register ----------------
   logic [177:0] out_ff;

   always_ff @(posedge clock) begin
      if (adv4) begin
         out_ff <= {s3_sum_ff[7], s3_sum_ff[6], s3_sum_ff[5], s3_sum_ff[4],
                    s3_bottom, s3_right, s3_top, s3_left,
                    s3_conf_ff, s3_idx_ff};
      end
   end

   assign rsp_tdata  = {6'b0, out_ff};
   assign rsp_tvalid = v4_ff;

   // ---------------- assertions ----------------
   // backpressure reaches the input only with the whole pipe full
   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("req_tready low with an empty stage");

   // a held stage three keeps its score for the threshold test
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !adv3) |=> (v3_ff && $stable(s3_conf_ff) && $stable(s3_idx_ff)))
      else $error("stage three lost or changed while stalled");

   // a row dropped under threshold never reaches the output
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (adv4 && v3_ff && !hit) |=> !v4_ff)
      else $error("below-threshold row emitted");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : anchor box decoder with score threshold
// Streams detector rows into the core, predicts each detection from the
// logit, the anchor grid and the threshold register, and checks every
// decoded beat field by field. A directed table opens the run, then random
// rows follow under several threshold settings, with random idling on both
// streams except in the final phase.
// ---------------------------------------------------------------------------
module testbench;

   // Cycles without any beat before the run is declared hung
   localparam int StallLimit   = 2000;
   // Pipeline depth plus margin, waited out before a register write
   localparam int SettleCycles = 8;
   localparam int PhaseCount   = 8;
   localparam int PhaseRows    = 66;

   // Row fields, last member first so the struct matches req_tdata[169:0]
   typedef struct packed {
      abd_pkg::regr_type  second_point_y;
      abd_pkg::regr_type  second_point_x;
      abd_pkg::regr_type  first_point_y;
      abd_pkg::regr_type  first_point_x;
      abd_pkg::regr_type  box_height;
      abd_pkg::regr_type  box_width;
      abd_pkg::regr_type  box_center_y;
      abd_pkg::regr_type  box_center_x;
      abd_pkg::logit_type raw_score;
      abd_pkg::index_type anchor_index;
   } detector_row_type;

   // Detection fields, laid out as rsp_tdata[177:0]
   typedef struct packed {
      abd_pkg::coord_type point_b_y;
      abd_pkg::coord_type point_b_x;
      abd_pkg::coord_type point_a_y;
      abd_pkg::coord_type point_a_x;
      abd_pkg::coord_type bottom_edge;
      abd_pkg::coord_type right_edge;
      abd_pkg::coord_type top_edge;
      abd_pkg::coord_type left_edge;
      abd_pkg::conf_type  confidence;
      abd_pkg::index_type hit_index;
   } detection_type;

   // One directed row; typed rows carry their detection written out by hand
   typedef struct packed {
      detector_row_type   row;
      logic               typed;
      logic               emit;
      abd_pkg::conf_type  conf;
      abd_pkg::coord_type coord;
   } directed_row_type;

   logic         clock;
   logic         reset;
   logic [175:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [183:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  csr_data;
   logic         csr_valid;
   logic         csr_ready;

   detection_type     pending_hits[$];
   directed_row_type  stimulus_table[$];
   abd_pkg::conf_type live_threshold;
   int                errors = 0;
   int                quiet_cycles = 0;
   bit                calm;

   anchor_box_decode_threshold_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // floor((t + 1) / 2): halves, ties rounded up
   function automatic int halve_up(input int t);
      return (t + 1) >>> 1;
   endfunction

   // Score the logit, test it against the threshold and decode the row.
   // Return 1 when the row yields a detection.
   function automatic bit decode_detection(input detector_row_type r,
                                           input abd_pkg::conf_type thr,
                                           output detection_type d);
      int x, a, p, idx, grid_pos, ax, ay, cx, cy, w, h;
      d = '0;
      // clip to +-100.0, then the piecewise sigmoid on |x|
      x = int'(r.raw_score);
      if (x > 25600) x = 25600;
      if (x < -25600) x = -25600;
      a = (x < 0) ? -x : x;
      if (a >= 1280) p = 65536;
      else if (a >= 608) p = 8 * a + 55296;
      else if (a >= 256) p = 32 * a + 40960;
      else p = 64 * a + 32768;
      if (x < 0) p = 65536 - p;
      if (p > 65535) p = 65535;
      if (p < int'(thr)) return 1'b0;

      // anchor centre: fine 16x16 grid, two per cell, then coarse 8x8 grid,
      // six per cell; indexes past the last anchor stay in the last cell
      idx = int'(r.anchor_index);
      if (idx < 512) begin
         grid_pos = idx >> 1;
         ax = (2 * (grid_pos % 16) + 1) * 1024;
         ay = (2 * (grid_pos / 16) + 1) * 1024;
      end else begin
         grid_pos = (idx - 512) / 6;
         if (grid_pos > 63) grid_pos = 63;
         ax = (2 * (grid_pos % 8) + 1) * 2048;
         ay = (2 * (grid_pos / 8) + 1) * 2048;
      end

      cx = int'(r.box_center_x) + ax;
      cy = int'(r.box_center_y) + ay;
      w  = int'(r.box_width);
      h  = int'(r.box_height);
      d.hit_index   = r.anchor_index;
      d.confidence  = abd_pkg::conf_type'(p);
      d.left_edge   = abd_pkg::coord_type'(halve_up(2 * cx - w));
      d.top_edge    = abd_pkg::coord_type'(halve_up(2 * cy - h));
      d.right_edge  = abd_pkg::coord_type'(halve_up(2 * cx + w));
      d.bottom_edge = abd_pkg::coord_type'(halve_up(2 * cy + h));
      d.point_a_x   = abd_pkg::coord_type'(int'(r.first_point_x) + ax);
      d.point_a_y   = abd_pkg::coord_type'(int'(r.first_point_y) + ay);
      d.point_b_x   = abd_pkg::coord_type'(int'(r.second_point_x) + ax);
      d.point_b_y   = abd_pkg::coord_type'(int'(r.second_point_y) + ay);
      return 1'b1;
   endfunction

   // Mostly modest offsets, a quarter across the full 18-bit range
   function automatic abd_pkg::regr_type random_regr();
      if ($urandom_range(0, 3) == 0) return abd_pkg::regr_type'($urandom);
      return abd_pkg::regr_type'(int'($urandom_range(0, 8191)) - 4096);
   endfunction

   function automatic detector_row_type random_row();
      detector_row_type r;
      int               knee;
      // index: mostly anywhere, sometimes on a grid boundary or past the end
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 5))
            0: r.anchor_index = 10'd0;
            1: r.anchor_index = 10'd511;
            2: r.anchor_index = 10'd512;
            3: r.anchor_index = 10'd895;
            4: r.anchor_index = 10'd896;
            default: r.anchor_index = 10'd1023;
         endcase
      end else begin
         r.anchor_index = abd_pkg::index_type'($urandom_range(0, 1023));
      end
      // logit: full range, the curved part, or hugging a knee
      case ($urandom_range(0, 3))
         0: r.raw_score = abd_pkg::logit_type'($urandom);
         3: begin
            case ($urandom_range(0, 3))
               0: knee = 256;
               1: knee = 608;
               2: knee = 1280;
               default: knee = 25600;
            endcase
            knee = knee + int'($urandom_range(0, 4)) - 2;
            r.raw_score = abd_pkg::logit_type'($urandom_range(0, 1) ? knee : -knee);
         end
         default: r.raw_score = abd_pkg::logit_type'(int'($urandom_range(0, 2800)) - 1400);
      endcase
      r.box_center_x   = random_regr();
      r.box_center_y   = random_regr();
      r.box_width      = random_regr();
      r.box_height     = random_regr();
      r.first_point_x  = random_regr();
      r.first_point_y  = random_regr();
      r.second_point_x = random_regr();
      r.second_point_y = random_regr();
      return r;
   endfunction

   task automatic add_row(input int idx, score, bcx, bcy, bw, bh, pax, pay, pbx, pby,
                          input bit typed, emit, input int tconf, tcoord);
      directed_row_type e;
      e.row.anchor_index   = abd_pkg::index_type'(idx);
      e.row.raw_score      = abd_pkg::logit_type'(score);
      e.row.box_center_x   = abd_pkg::regr_type'(bcx);
      e.row.box_center_y   = abd_pkg::regr_type'(bcy);
      e.row.box_width      = abd_pkg::regr_type'(bw);
      e.row.box_height     = abd_pkg::regr_type'(bh);
      e.row.first_point_x  = abd_pkg::regr_type'(pax);
      e.row.first_point_y  = abd_pkg::regr_type'(pay);
      e.row.second_point_x = abd_pkg::regr_type'(pbx);
      e.row.second_point_y = abd_pkg::regr_type'(pby);
      e.typed = typed;
      e.emit  = emit;
      e.conf  = abd_pkg::conf_type'(tconf);
      e.coord = abd_pkg::coord_type'(tcoord);
      stimulus_table.insert(stimulus_table.size(), e);
   endtask

   // Drive one row beat, with a random idle burst ahead of it, and queue the
   // detection it should produce once the beat is taken
   task automatic send_row(input detector_row_type r, input bit typed, emit,
                           input abd_pkg::conf_type tconf,
                           input abd_pkg::coord_type tcoord);
      detection_type d;
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r};
      do @(posedge clock); while (!req_tready);
      if (typed) begin
         if (emit) begin
            d.hit_index   = r.anchor_index;
            d.confidence  = tconf;
            d.left_edge   = tcoord;
            d.top_edge    = tcoord;
            d.right_edge  = tcoord;
            d.bottom_edge = tcoord;
            d.point_a_x   = tcoord;
            d.point_a_y   = tcoord;
            d.point_b_x   = tcoord;
            d.point_b_y   = tcoord;
            pending_hits.insert(pending_hits.size(), d);
         end
      end else if (decode_detection(r, live_threshold, d)) begin
         pending_hits.insert(pending_hits.size(), d);
      end
   endtask

   // Drop valid, wait for every queued detection, then let the pipeline empty
   // of rows under threshold before anything touches the register
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_threshold(input abd_pkg::conf_type level);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      live_threshold = level;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Result side: random ready bursts, steady ready in the final phase
   initial begin
      int run_len;
      bit stall;
      rsp_tready = 1'b0;
      forever begin
         if (calm) begin
            @(negedge clock) rsp_tready <= 1'b1;
         end else begin
            stall   = ($urandom_range(0, 2) == 0);
            run_len = stall ? $urandom_range(1, 13) : $urandom_range(1, 24);
            repeat (run_len) @(negedge clock) rsp_tready <= !stall;
         end
      end
   end

   // Compare each detection beat with the oldest prediction
   always @(posedge clock) begin
      detection_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = detection_type'(rsp_tdata[177:0]);
         if (pending_hits.size() == 0) begin
            $display("%0t ns: detection for index %0d with none expected, expected none",
                     $time, got.hit_index);
            errors++;
         end else begin
            want = pending_hits.pop_front();
            check_field("hit_index", int'(want.hit_index), int'(got.hit_index));
            check_field("confidence", int'(want.confidence), int'(got.confidence));
            check_field("left_edge", int'(want.left_edge), int'(got.left_edge));
            check_field("top_edge", int'(want.top_edge), int'(got.top_edge));
            check_field("right_edge", int'(want.right_edge), int'(got.right_edge));
            check_field("bottom_edge", int'(want.bottom_edge), int'(got.bottom_edge));
            check_field("point_a_x", int'(want.point_a_x), int'(got.point_a_x));
            check_field("point_a_y", int'(want.point_a_y), int'(got.point_a_y));
            check_field("point_b_x", int'(want.point_b_x), int'(got.point_b_x));
            check_field("point_b_y", int'(want.point_b_y), int'(got.point_b_y));
         end
      end
   end

   // Watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      abd_pkg::conf_type level;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      calm           = 1'b0;
      live_threshold = abd_pkg::ThresholdReset;

      // Directed rows, run at the reset threshold of one half.
      // Typed rows: zero regressors put every coordinate on the anchor centre.
      //      idx   score   cx      cy      w       h       pax     pay     pbx     pby
      add_row(0,    0,      0,      0,      0,      0,      0,      0,      0,      0,
              1, 1, 32768, 1024);      // score exactly at threshold, first anchor
      add_row(895,  32767,  0,      0,      0,      0,      0,      0,      0,      0,
              1, 1, 65535, 30720);     // saturated score, last anchor
      add_row(1023, 1280,   0,      0,      0,      0,      0,      0,      0,      0,
              1, 1, 65535, 30720);     // index past the end, last cell
      add_row(100,  -32768, 0,      0,      0,      0,      0,      0,      0,      0,
              1, 0, 0, 0);             // most negative logit, dropped
      add_row(1,    -1,     0,      0,      0,      0,      0,      0,      0,      0,
              1, 0, 0, 0);             // just under threshold, dropped
      add_row(511,  255,    131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071,
              0, 0, 0, 0);
      add_row(512,  256,    -131072, -131072, -131072, -131072, -131072, -131072,
              -131072, -131072, 0, 0, 0, 0);
      add_row(517,  607,    131071, -131072, -131072, 131071, 1, -1, 131071, -131072,
              0, 0, 0, 0);
      add_row(518,  608,    3,      -3,     1,      -1,     5,      -5,     7,      -7,
              0, 0, 0, 0);             // odd sizes: rounding ties
      add_row(2,    1279,   -3,     3,      3,      -3,     0,      1,      -1,     0,
              0, 0, 0, 0);
      add_row(31,   -256,   100,    200,    300,    400,    500,    600,    700,    800,
              0, 0, 0, 0);
      add_row(32,   -608,   -100,   -200,   -300,   -400,   -500,   -600,   -700,   -800,
              0, 0, 0, 0);
      add_row(255,  -1279,  1,      2,      3,      4,      5,      6,      7,      8,
              0, 0, 0, 0);
      add_row(256,  25600,  4096,   -4096,  2048,   2048,   -1024,  1024,   0,      0,
              0, 0, 0, 0);
      add_row(513,  -25600, 0,      0,      0,      0,      0,      0,      0,      0,
              0, 0, 0, 0);
      add_row(894,  25601,  -8192,  8192,   511,    -511,   9,      -9,     65536,  -65536,
              0, 0, 0, 0);
      add_row(600,  -25601, 0,      0,      0,      0,      0,      0,      0,      0,
              0, 0, 0, 0);
      add_row(17,   127,    0,      0,      -131072, -131072, 0,    0,      0,      0,
              0, 0, 0, 0);             // negative box size
      add_row(1000, 32767,  131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071,
              0, 0, 0, 0);
      add_row(700,  32767,  -131072, -131072, -131072, -131072, -131072, -131072,
              -131072, -131072, 0, 0, 0, 0);

      // Hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (stimulus_table[i])
         send_row(stimulus_table[i].row, stimulus_table[i].typed, stimulus_table[i].emit,
                  stimulus_table[i].conf, stimulus_table[i].coord);
      settle();

      // Random phases across threshold settings, extremes first; the last
      // phase runs with both streams flat out
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: level = '0;
            1: level = abd_pkg::ConfMax;
            2: level = 16'd1;
            3: level = abd_pkg::ThresholdReset;
            6: level = abd_pkg::ConfMax - 16'd1;
            default: level = abd_pkg::conf_type'($urandom_range(0, 65535));
         endcase
         set_threshold(level);
         calm = (p == PhaseCount - 1);
         repeat (PhaseRows) send_row(random_row(), 1'b0, 1'b0, '0, '0);
         settle();
      end

      if (errors == 0 && pending_hits.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: anchor_box_decode_threshold_core.f
rtl/abd_pkg.sv
rtl/abd_anchor.sv
rtl/abd_sigmoid.sv
rtl/abd_edge.sv
rtl/anchor_box_decode_threshold_core.sv
sim/testbench.sv
